// ----- src/psp_pkg.sv -----
package psp_pkg;

    // angle fraction bits (1/64 degree by default)
    localparam int ANGLE_FRAC_BITS = 6;

    localparam int NUM_LEGS = 6;
    localparam int PERIOD_W = 15;
    localparam int DELAY_W  = 13;
    localparam int LEAD_W   = 16;
    localparam int SHIFT_W  = 14;
    localparam int LEG_W    = 3;
    localparam int MODE_W   = 2;

    // full turn in half angle units: 720 << frac = 45 << (frac + 4)
    localparam int FULL_TURN = 720 << ANGLE_FRAC_BITS;
    localparam int TURN_ODD  = 45;
    localparam int QUARTER   = 180 << ANGLE_FRAC_BITS;
    localparam int TURN_W    = $clog2(FULL_TURN);

    // offset that lifts every raw phase above zero before reduction
    localparam int RED_OFFSET = FULL_TURN * ((1 << 17) / FULL_TURN + 1);
    localparam int RED_MAX    = RED_OFFSET + 5 * FULL_TURN;
    localparam int RAW_W      = $clog2(RED_MAX) + 1;
    localparam int RED_STEPS  = $clog2(RED_MAX / FULL_TURN + 1);
    localparam int RED_W      = TURN_W + RED_STEPS;
    localparam int STEP_W     = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    // divide by the full turn: shift out the power of two, then multiply
    // by the reciprocal of 45 (exact for quotients of 21 bit dividends)
    localparam int X_SHIFT     = ANGLE_FRAC_BITS + 4;
    localparam int X_W         = 21;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + TURN_ODD - 1) / TURN_ODD;
    localparam int RECIP_W     = 22;
    localparam int MUL_W0      = (TURN_W > RECIP_W) ? TURN_W : RECIP_W;
    localparam int MUL_W       = (MUL_W0 > X_W) ? MUL_W0 : X_W;
    localparam int PROD_W      = 2 * MUL_W;

    localparam logic [LEG_W-1:0] LEG_LEAD  = 3'd0;
    localparam logic [LEG_W-1:0] LEG_LAG   = 3'd1;
    localparam logic [LEG_W-1:0] LEG_P     = 3'd2;
    localparam logic [LEG_W-1:0] LEG_Q     = 3'd3;
    localparam logic [LEG_W-1:0] LEG_THIRD = 3'd4;
    localparam logic [LEG_W-1:0] LEG_FIFTH = 3'd5;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_CROSS_A = 2'd1,
        MODE_CROSS_B = 2'd2
    } mode_t;

    typedef struct packed {
        logic             start;
        logic [RED_W-1:0] init;
    } red_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [TURN_W-1:0] value;
    } red_stat_t;

endpackage

// ----- src/psp_reduce.sv -----
module psp_reduce
    import psp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  red_ctrl_t ctrl,
    output red_stat_t stat
);

    logic [RED_W-1:0]  val_reg;
    logic [RED_W-1:0]  val_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [RED_W-1:0]  sub;

    // restoring reduction: subtract turn << k, k from high to low
    assign sub = RED_W'(FULL_TURN) << step_reg;

    always_comb
    begin
        val_next  = val_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            val_next  = ctrl.init;
            step_next = STEP_W'(RED_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (val_reg >= sub)
            begin
                val_next = val_reg - sub;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign stat.done  = done_reg;
    assign stat.value = val_reg[TURN_W-1:0];

endmodule

// ----- src/psp_mul.sv -----
module psp_mul
    import psp_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ----- src/phase_shift_pwm_compare_update.sv -----
// Phase-shifted PWM compare update for a six-leg bridge. Each input item
// (lead phase L, shift angle S, command) yields one result item per leg:
// lead, lag, P, Q, third and fifth (command 1 updates P, Q, third and fifth
// only), in leg order, with tlast on the fifth-harmonic leg. Phases are held
// in half angle units so S/2 is exact, reduced into one turn, and turned into
// compare A = floor(period * phase / turn) and compare B = A + period/2
// wrapped into the period; a leg is flagged when A or B jumps upwards by at
// least half a period against its stored compares. The shared reduction unit
// does one conditional subtract per cycle over four steps per phase with the
// default 6-bit angle fraction, and each leg passes twice through the shared
// multiplier (product, then reciprocal of 45). The block takes no new item
// while an update is in flight; results leave through an output register.
// Registers (APB, word addressed): 0x0 pwm_period (reset 1000), 0x4
// drive_delay_phase (13-bit signed, reset 0); write them only while idle.
module phase_shift_pwm_compare_update
    import psp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // lead_phase[15:0], shift_angle[29:16]
    input  logic [0:0]  s_tuser,    // command[0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // leg_index[2:0], compare_a[17:3],
                                    // compare_b[32:18], action_mode[34:33]
    output logic        m_tlast
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_QRED = 7'b0000010,
        ST_LOAD = 7'b0000100,
        ST_RED  = 7'b0001000,
        ST_MUL1 = 7'b0010000,
        ST_MUL2 = 7'b0100000,
        ST_CALC = 7'b1000000
    } state_t;

    // configuration registers
    logic [PERIOD_W-1:0]       period_reg;
    logic signed [DELAY_W-1:0] delay_reg;
    logic                      cfg_write;

    // sequencer
    state_t                    state_reg;
    state_t                    state_next;
    logic [LEG_W-1:0]          leg_reg;
    logic [LEG_W-1:0]          leg_next;

    // per-item phase data
    logic signed [RAW_W-1:0]   r0_reg;
    logic signed [RAW_W-1:0]   r1_reg;
    logic [TURN_W-1:0]         qr_reg;
    logic [PERIOD_W-1:0]       a_reg;
    logic [PERIOD_W-1:0]       b_reg;

    // stored compares of each leg
    logic [PERIOD_W-1:0]       prev_a_reg [NUM_LEGS];
    logic [PERIOD_W-1:0]       prev_b_reg [NUM_LEGS];

    // output register
    logic                      out_valid_reg;
    logic [LEG_W-1:0]          out_leg_reg;
    logic [PERIOD_W-1:0]       out_a_reg;
    logic [PERIOD_W-1:0]       out_b_reg;
    mode_t                     out_mode_reg;
    logic                      out_last_reg;
    logic                      out_free;
    logic                      emit;

    // input unpacking and raw phases in half angle units
    logic signed [LEAD_W-1:0]  lead_in;
    logic [SHIFT_W-1:0]        shift_in;
    logic signed [RAW_W-1:0]   lead_x;
    logic signed [RAW_W-1:0]   shift_x;
    logic signed [RAW_W-1:0]   delay_x;
    logic signed [RAW_W-1:0]   r0_in;
    logic signed [RAW_W-1:0]   r1_in;
    logic signed [RAW_W-1:0]   rq_in;
    logic signed [RAW_W-1:0]   q_x;
    logic signed [RAW_W-1:0]   raw_leg;
    logic signed [RAW_W-1:0]   raw_sel;
    logic                      accept;

    // shared units
    red_ctrl_t                 red_ctrl;
    red_stat_t                 red_stat;
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [PROD_W-1:0]         prod;
    logic [X_W-1:0]            quot_x;
    logic [PERIOD_W-1:0]       cmp_a;

    // compare B and crossing detection
    logic [PERIOD_W-1:0]       half;
    logic [PERIOD_W:0]         b_sum;
    logic [PERIOD_W-1:0]       b_wrap;
    logic [PERIOD_W-1:0]       prev_a;
    logic [PERIOD_W-1:0]       prev_b;
    logic [PERIOD_W-1:0]       diff_a;
    logic [PERIOD_W-1:0]       diff_b;
    mode_t                     mode;

    // ---------------------------------------------------------------
    // configuration port, always ready, word decode on paddr[2]
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_W'(1000);
            delay_reg  <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                delay_reg <= pwdata[DELAY_W-1:0];
            end
            else
            begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? 32'(delay_reg) : 32'(period_reg);

    // ---------------------------------------------------------------
    // raw phases: lead 2L, lag 2L-2S, Q 2L-S+2D (half angle units)
    // ---------------------------------------------------------------
    assign lead_in = s_tdata[LEAD_W-1:0];
    assign shift_in = s_tdata[LEAD_W +: SHIFT_W];
    assign lead_x  = RAW_W'(lead_in);
    assign shift_x = signed'(RAW_W'(shift_in));
    assign delay_x = RAW_W'(delay_reg);
    assign r0_in   = lead_x + lead_x;
    assign r1_in   = r0_in - shift_x - shift_x;
    assign rq_in   = r0_in - shift_x + delay_x + delay_x;

    assign q_x = signed'(RAW_W'(qr_reg));

    // P, Q, third and fifth leg phases derived from the reduced Q phase; lead and lag use the raw phases
    always_comb
    begin
        unique case (leg_reg)
            LEG_LEAD:  raw_leg = r0_reg;
            LEG_LAG:   raw_leg = r1_reg;
            LEG_P:     raw_leg = q_x + RAW_W'(QUARTER);
            LEG_Q:     raw_leg = q_x;
            LEG_THIRD: raw_leg = q_x + (q_x <<< 1);
            LEG_FIFTH: raw_leg = q_x + (q_x <<< 2);
            default:   raw_leg = q_x;
        endcase
    end

    assign accept  = s_tvalid && s_tready;
    assign raw_sel = (state_reg == ST_IDLE) ? rq_in : raw_leg;

    assign red_ctrl.start = accept || (state_reg == ST_LOAD);
    assign red_ctrl.init  = RED_W'(raw_sel + RAW_W'(RED_OFFSET));

    psp_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (red_ctrl),
        .stat  (red_stat)
    );

    // ---------------------------------------------------------------
    // shared multiplier: period * phase, then (product >> k) * 1/45
    // ---------------------------------------------------------------
    assign quot_x = prod[X_SHIFT +: X_W];
    assign cmp_a  = prod[RECIP_SHIFT +: PERIOD_W];

    always_comb
    begin
        if (state_reg == ST_MUL1)
        begin
            mul_a = MUL_W'(quot_x);
            mul_b = MUL_W'(RECIP);
        end
        else
        begin
            mul_a = MUL_W'(period_reg);
            mul_b = MUL_W'(red_stat.value);
        end
    end

    psp_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // ---------------------------------------------------------------
    // compare B and crossing detection
    // ---------------------------------------------------------------
    assign half   = period_reg >> 1;
    assign b_sum  = {1'b0, half} + {1'b0, cmp_a};
    assign b_wrap = (b_sum >= {1'b0, period_reg}) ?
                    PERIOD_W'(b_sum - {1'b0, period_reg}) : b_sum[PERIOD_W-1:0];

    assign prev_a = prev_a_reg[leg_reg];
    assign prev_b = prev_b_reg[leg_reg];
    assign diff_a = (a_reg >= prev_a) ? (a_reg - prev_a) : (prev_a - a_reg);
    assign diff_b = (b_reg >= prev_b) ? (b_reg - prev_b) : (prev_b - b_reg);

    // A has priority over B
    always_comb
    begin
        if ((diff_a >= half) && (a_reg >= half))
        begin
            mode = MODE_CROSS_A;
        end
        else if ((diff_b >= half) && (b_reg >= half))
        begin
            mode = MODE_CROSS_B;
        end
        else
        begin
            mode = MODE_NORMAL;
        end
    end

    // ---------------------------------------------------------------
    // sequencer: reduce Q, then per leg reduce, two multiplies, emit
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (state_reg == ST_CALC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        leg_next   = leg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_QRED;
                    leg_next   = s_tuser[0] ? LEG_P : LEG_LEAD;
                end
            end
            ST_QRED:
            begin
                if (red_stat.done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                if (red_stat.done)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (out_free)
                begin
                    if (leg_reg == LEG_FIFTH)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                        leg_next   = leg_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            leg_reg   <= LEG_LEAD;
        end
        else
        begin
            state_reg <= state_next;
            leg_reg   <= leg_next;
        end
    end

    // phase and compare data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r0_reg <= r0_in;
            r1_reg <= r1_in;
        end
        if ((state_reg == ST_QRED) && red_stat.done)
        begin
            qr_reg <= red_stat.value;
        end
        if (state_reg == ST_MUL2)
        begin
            a_reg <= cmp_a;
            b_reg <= b_wrap;
        end
    end

    // stored compares, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEGS; i++)
            begin
                prev_a_reg[i] <= '0;
                prev_b_reg[i] <= '0;
            end
        end
        else if (emit)
        begin
            prev_a_reg[leg_reg] <= a_reg;
            prev_b_reg[leg_reg] <= b_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_leg_reg  <= leg_reg;
            out_a_reg    <= a_reg;
            out_b_reg    <= b_reg;
            out_mode_reg <= mode;
            out_last_reg <= (leg_reg == LEG_FIFTH);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_mode_reg, out_b_reg, out_a_reg, out_leg_reg};
    assign m_tlast  = out_last_reg;

endmodule
